>>> rtl/edl_pkg.sv
// ----------------------------------------------------------------------------
// edl_pkg
// shared types, codes and constants for the exact limb divider
// ----------------------------------------------------------------------------
package edl_pkg;

   localparam int LIMB_BITS_DEFAULT = 64;   // default limb width
   localparam int LIMB_PORT_WIDTH   = 64;   // width of the data ports
   localparam int SEL_WIDTH         = 2;    // divisor select register
   localparam int CARRY_WIDTH       = 4;    // running carry, never above 8
   localparam int DIV_WIDTH         = 4;    // divisor value, at most 9

   // divisor select codes
   localparam logic [SEL_WIDTH-1:0] SEL_DIV3  = 2'd0;
   localparam logic [SEL_WIDTH-1:0] SEL_DIV5  = 2'd1;
   localparam logic [SEL_WIDTH-1:0] SEL_DIV9  = 2'd2;
   localparam logic [SEL_WIDTH-1:0] SEL_ALIAS = 2'd3;

   localparam logic [DIV_WIDTH-1:0] DIV_THREE = 4'd3;
   localparam logic [DIV_WIDTH-1:0] DIV_FIVE  = 4'd5;
   localparam logic [DIV_WIDTH-1:0] DIV_NINE  = 4'd9;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_DONE
   } edl_state_type;

   // top level to serial unit
   typedef struct packed {
      logic start;   // load a new limb
      logic take;    // finished result moved to the output register
   } edl_ctrl_type;

   // serial unit to top level
   typedef struct packed {
      logic busy;    // limb in flight or result not yet taken
      logic done;    // quotient and carry are final
   } edl_status_type;

   // odd divisor for a select code; the spare code behaves as divide by 3
   function automatic logic [DIV_WIDTH-1:0] edl_divisor(input logic [SEL_WIDTH-1:0] sel);
      logic [DIV_WIDTH-1:0] d;
      unique case (sel)
         SEL_DIV3:  d = DIV_THREE;
         SEL_DIV5:  d = DIV_FIVE;
         SEL_DIV9:  d = DIV_NINE;
         SEL_ALIAS: d = DIV_THREE;
         default:   d = DIV_THREE;
      endcase
      return d;
   endfunction

endpackage

>>> rtl/edl_serial_div.sv
// ----------------------------------------------------------------------------
// edl_serial_div
// bit-serial exact division of one limb by a small odd divisor
// ----------------------------------------------------------------------------
module edl_serial_div #(
   parameter int LIMB_BITS = edl_pkg::LIMB_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  edl_pkg::edl_ctrl_type           ctrl,
   input  logic [LIMB_BITS-1:0]            limb,
   input  logic [edl_pkg::DIV_WIDTH-1:0]   divisor,
   input  logic [edl_pkg::CARRY_WIDTH-1:0] carry_in,
   output edl_pkg::edl_status_type         status,
   output logic [LIMB_BITS-1:0]            quotient,
   output logic [edl_pkg::CARRY_WIDTH-1:0] carry_out
);
   import edl_pkg::*;

   localparam int CNT_W = $clog2(LIMB_BITS);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LIMB_BITS - 1);

   edl_state_type state_ff, state_in;

   logic [LIMB_BITS-1:0]   x_ff, x_in;
   logic [LIMB_BITS-1:0]   q_ff, q_in;
   logic [CARRY_WIDTH-1:0] acc_ff, acc_in;
   logic [DIV_WIDTH-1:0]   d_ff, d_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;

   logic                   q_bit;
   logic [CARRY_WIDTH:0]   step_sum;
   logic                   shift_en;

   // one quotient bit per cycle: pick the bit that makes acc + q*d - x even
   always_comb begin
      q_bit    = x_ff[0] ^ acc_ff[0];
      step_sum = {1'b0, acc_ff}
               + (q_bit ? {1'b0, d_ff} : '0)
               - {{CARRY_WIDTH{1'b0}}, x_ff[0]};
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (ctrl.start) state_in = ST_SHIFT;
         ST_SHIFT: if (cnt_ff == CNT_LAST) state_in = ST_DONE;
         ST_DONE:  if (ctrl.take) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      status.busy = 1'b0;
      status.done = 1'b0;
      shift_en    = 1'b0;
      unique case (state_ff)
         ST_IDLE:  ;
         ST_SHIFT: begin
            status.busy = 1'b1;
            shift_en    = 1'b1;
         end
         ST_DONE:  begin
            status.busy = 1'b1;
            status.done = 1'b1;
         end
         default:  ;
      endcase
   end

   // datapath
   always_comb begin
      x_in   = x_ff;
      q_in   = q_ff;
      acc_in = acc_ff;
      d_in   = d_ff;
      cnt_in = cnt_ff;
      if (ctrl.start && (state_ff == ST_IDLE)) begin
         x_in   = limb;
         acc_in = carry_in;
         d_in   = divisor;
         cnt_in = '0;
      end else if (shift_en) begin
         x_in   = {1'b0, x_ff[LIMB_BITS-1:1]};
         q_in   = {q_bit, q_ff[LIMB_BITS-1:1]};
         acc_in = step_sum[CARRY_WIDTH:1];
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      q_ff   <= q_in;
      acc_ff <= acc_in;
      d_ff   <= d_in;
      cnt_ff <= cnt_in;
   end

   assign quotient  = q_ff;
   assign carry_out = acc_ff;

endmodule

>>> rtl/exact_divide_limbs_by_small_constant_core.sv
// ----------------------------------------------------------------------------
// exact_divide_limbs_by_small_constant_core
// exact division of a multi-limb unsigned number by 3, 5 or 9
// ----------------------------------------------------------------------------
// Limbs enter least significant first on the req stream, one per word, and
// the quotient limb at the same position leaves on the rsp stream with tlast
// copied through. csr_wdata picks the divisor (0: 3, 1: 5, 2: 9, 3: 3) and is
// sampled when a limb is accepted. The dividend is expected to be divisible;
// otherwise the quotient limbs are those of the usual modular-inverse
// recurrence and the leftover carry is dropped after tlast. Each limb runs
// through a bit-serial divider that produces one quotient bit per clock,
// and the finished quotient is then handed off to the rsp register; the
// next limb is taken once the previous quotient has moved into the rsp
// register, which may still be waiting on rsp_tready, so a new limb is
// not taken while the last one is in flight, and a full rsp register
// holds up the hand-off. Only the low LIMB_BITS bits of req_tdata are used
// and rsp_tdata is zero above them.
// No clearing pass after reset.
// ----------------------------------------------------------------------------
module exact_divide_limbs_by_small_constant_core #(
   parameter int LIMB_BITS = edl_pkg::LIMB_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // input words
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [edl_pkg::LIMB_PORT_WIDTH-1:0] req_tdata,   // limb
   input  logic                                req_tlast,   // last
   // result words
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [edl_pkg::LIMB_PORT_WIDTH-1:0] rsp_tdata,   // quotient_limb
   output logic                                rsp_tlast,   // last_out
   // divisor select register
   input  logic                                csr_we,
   input  logic [edl_pkg::SEL_WIDTH-1:0]       csr_wdata    // divisor_select
);
   import edl_pkg::*;

   edl_ctrl_type   ctrl;
   edl_status_type status;

   logic [SEL_WIDTH-1:0]       sel_ff, sel_in;
   logic [CARRY_WIDTH-1:0]     carry_ff, carry_in;
   logic                       last_ff, last_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [LIMB_PORT_WIDTH-1:0] rsp_data_ff, rsp_data_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic [LIMB_BITS-1:0]       quotient;
   logic [CARRY_WIDTH-1:0]     carry_out;

   // a limb is loaded whenever the serial unit is free
   assign req_tready = !status.busy;
   assign ctrl.start = req_tvalid && req_tready;
   // finished quotient moves on once the rsp register is empty or draining
   assign ctrl.take  = status.done && (!rsp_valid_ff || rsp_tready);

   edl_serial_div #(
      .LIMB_BITS (LIMB_BITS)
   ) u_serial (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .limb      (req_tdata[LIMB_BITS-1:0]),
      .divisor   (edl_divisor(sel_ff)),
      .carry_in  (carry_ff),
      .status    (status),
      .quotient  (quotient),
      .carry_out (carry_out)
   );

   always_comb begin
      sel_in       = csr_we ? csr_wdata : sel_ff;
      last_in      = ctrl.start ? req_tlast : last_ff;
      carry_in     = carry_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (ctrl.take) begin
         // carry restarts from zero after the top limb of a number
         carry_in     = last_ff ? '0 : carry_out;
         rsp_valid_in = 1'b1;
         rsp_data_in  = LIMB_PORT_WIDTH'(quotient);
         rsp_last_in  = last_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff       <= SEL_DIV3;
         carry_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sel_ff       <= sel_in;
         carry_ff     <= carry_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// stream test of the exact limb divider against an own prediction
// ----------------------------------------------------------------------------
// Numbers go in least significant limb first. Most of them are true products
// of a random quotient and the divisor in use, so the divider walks through
// real carry chains. The rest are single noise words and numbers that do not
// divide. The divisor is changed between phases, sometimes in the middle of a
// number. Both streams idle and stall at random, and every quotient word is
// checked against the predicted one in order.
// ----------------------------------------------------------------------------
module testbench;

   import edl_pkg::*;

   localparam int LIMB_LATENCY = LIMB_BITS_DEFAULT + 1;   // acceptance to rsp register

   // modular inverses of the divisors modulo 2^64
   localparam logic [63:0] INVERSE_THREE = 64'hAAAA_AAAA_AAAA_AAAB;
   localparam logic [63:0] INVERSE_FIVE  = 64'hCCCC_CCCC_CCCC_CCCD;
   localparam logic [63:0] INVERSE_NINE  = 64'h8E38_E38E_38E3_8E39;

   // ready pattern of the second stall mode, one bit per cycle
   localparam logic [15:0] STALL_PATTERN = 16'b1011_0010_1110_0101;

   // one word on either stream: a limb and its last flag
   typedef struct packed {
      logic [63:0] value;
      logic        last;
   } limb_word_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [LIMB_PORT_WIDTH-1:0] req_tdata = '0;    // limb
   logic                       req_tlast = 1'b0;  // last
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [LIMB_PORT_WIDTH-1:0] rsp_tdata;         // quotient_limb
   logic                       rsp_tlast;         // last_out
   logic                       csr_we = 1'b0;
   logic [SEL_WIDTH-1:0]       csr_wdata = SEL_DIV3;

   // prediction state: divisor select as last written, and the carry
   logic [SEL_WIDTH-1:0]   active_select = SEL_DIV3;
   logic [CARRY_WIDTH-1:0] pending_carry = '0;

   limb_word_type  pending_limbs[$];       // words still to be sent
   limb_word_type  expected_quotients[$];  // predicted quotient words in order
   logic [63:0]    number_quotient[$];     // quotient limbs of the next product

   int             limbs_queued   = 0;
   int             sent_count     = 0;
   int             accepted_count = 0;
   int             mismatch_count = 0;
   int             burst_left     = 1;
   int             gap_left       = 0;
   int             stall_mode     = 0;
   int             stall_cycle    = 0;
   limb_word_type  next_word;
   limb_word_type  want_word;

   exact_divide_limbs_by_small_constant_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // the spare select code divides by 3
   function automatic logic [DIV_WIDTH-1:0] divisor_of(input logic [SEL_WIDTH-1:0] sel);
      case (sel)
         SEL_DIV5: return DIV_FIVE;
         SEL_DIV9: return DIV_NINE;
         default:  return DIV_THREE;
      endcase
   endfunction

   function automatic logic [63:0] inverse_of(input logic [SEL_WIDTH-1:0] sel);
      case (sel)
         SEL_DIV5: return INVERSE_FIVE;
         SEL_DIV9: return INVERSE_NINE;
         default:  return INVERSE_THREE;
      endcase
   endfunction

   // quotient limb of one accepted limb; advances the carry
   function automatic limb_word_type divide_limb(input logic [63:0] limb, input logic last);
      logic [63:0]   diff;
      logic [71:0]   scaled;
      limb_word_type quot;
      diff       = limb - {60'd0, pending_carry};
      quot.value = diff * inverse_of(active_select);
      quot.last  = last;
      // carry out is the part above bit 63 of quotient * divisor + carry in
      scaled = {8'd0, quot.value} * {68'd0, divisor_of(active_select)}
               + {68'd0, pending_carry};
      pending_carry = last ? '0 : scaled[67:64];
      return quot;
   endfunction

   // mostly plain random, with zero, all ones and single bits mixed in
   function automatic logic [63:0] random_limb();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return 64'd1 << $urandom_range(0, 63);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (mismatch_count < 100)
         $display("%0t ns: %s got %h wanted %h", $time, what, got, want);
      mismatch_count++;
   endtask

   task automatic push_word(input logic [63:0] value, input logic last);
      pending_limbs.push_back('{value: value, last: last});
      limbs_queued++;
   endtask

   // dividend = number_quotient * divisor, limb by limb; the top carry becomes
   // one more limb when it is not zero, so the number divides exactly
   task automatic push_product(input logic [SEL_WIDTH-1:0] sel);
      logic [71:0] acc;
      logic [7:0]  carry;
      carry = '0;
      foreach (number_quotient[i]) begin
         acc = {8'd0, number_quotient[i]} * {68'd0, divisor_of(sel)} + {64'd0, carry};
         push_word(acc[63:0], 1'b0);
         carry = acc[71:64];
      end
      if (carry != '0)
         push_word({56'd0, carry}, 1'b0);
      pending_limbs[pending_limbs.size()-1].last = 1'b1;
      number_quotient.delete();
   endtask

   // three in four are well-formed numbers of 1..5 quotient limbs, the rest
   // noise words that break or end numbers at random
   task automatic fill_random(input int count);
      int target;
      int limbs;
      logic [63:0] top;
      target = limbs_queued + count;
      while (limbs_queued < target) begin
         if ($urandom_range(0, 3) != 0) begin
            limbs = $urandom_range(1, 5);
            for (int i = 0; i < limbs; i++) begin
               top = random_limb();
               // a small top limb keeps the product to the same length
               if (i == limbs - 1 && $urandom_range(0, 1) == 1)
                  top[63:60] = 4'd0;
               number_quotient.push_back(top);
            end
            push_product(active_select);
         end else begin
            push_word(random_limb(), $urandom_range(0, 3) == 0);
         end
      end
   endtask

   // extremes for the divisor in use, ending with a number that does not divide
   task automatic push_extremes();
      push_word('1, 1'b1);
      push_word('0, 1'b1);
      number_quotient = {64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF};
      push_product(active_select);
      push_word('1, 1'b0);
      push_word(64'd1, 1'b1);
   endtask

   // everything sent, every quotient back, then the serial unit's latency
   task automatic wait_idle();
      while (pending_limbs.size() != 0 || accepted_count != sent_count
             || expected_quotients.size() != 0)
         @(negedge clock);
      repeat (LIMB_LATENCY + 8) @(negedge clock);
   endtask

   task automatic write_select(input logic [SEL_WIDTH-1:0] sel);
      @(negedge clock);
      csr_we        <= 1'b1;
      csr_wdata     <= sel;
      active_select  = sel;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // sender: bursts of words with random gaps, word held until taken
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && accepted_count != sent_count) begin
         // word still waiting for req_tready
      end else if (gap_left != 0) begin
         gap_left--;
         req_tvalid <= 1'b0;
      end else if (pending_limbs.size() != 0) begin
         next_word = pending_limbs.pop_front();
         req_tdata  <= next_word.value;
         req_tlast  <= next_word.last;
         req_tvalid <= 1'b1;
         sent_count++;
         if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 12);
            // a quarter of bursts follow on at once, the rest after a gap
            // that can outlast a whole limb
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
         end else begin
            burst_left--;
         end
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // receiver: one of four stall modes, picked afresh at random
   always @(negedge clock) begin
      stall_cycle++;
      if (stall_cycle % 512 == 0)
         stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= STALL_PATTERN[stall_cycle[3:0]];
         2:       rsp_tready <= 1'($urandom_range(0, 1));
         default: rsp_tready <= (stall_cycle % 9 == 0);
      endcase
   end

   // monitor: results checked before the new prediction is queued
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_quotients.size() == 0) begin
               report_mismatch("unexpected quotient word", rsp_tdata, '0);
            end else begin
               want_word = expected_quotients.pop_front();
               if (rsp_tdata !== want_word.value)
                  report_mismatch("quotient limb", rsp_tdata, want_word.value);
               if (rsp_tlast !== want_word.last)
                  report_mismatch("tlast", {63'd0, rsp_tlast}, {63'd0, want_word.last});
            end
         end
         if (req_tvalid && req_tready) begin
            expected_quotients.push_back(divide_limb(req_tdata, req_tlast));
            accepted_count++;
         end
      end
   end

   initial begin
      logic [SEL_WIDTH-1:0] phase_select[8];
      phase_select = '{SEL_DIV5, SEL_DIV9, SEL_ALIAS, SEL_DIV3,
                       SEL_DIV9, SEL_DIV5, SEL_ALIAS, SEL_DIV3};
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed words at the reset divisor of 3
      push_word('0, 1'b1);
      push_word('1, 1'b1);
      push_word(64'd1, 1'b1);          // does not divide
      push_word(64'd3, 1'b1);
      push_word(64'd2, 1'b1);          // does not divide
      push_word('1, 1'b0);             // carry into a second limb
      push_word('1, 1'b1);
      number_quotient = {64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF};
      push_product(active_select);
      number_quotient = {64'h8000_0000_0000_0000, 64'd1};
      push_product(active_select);
      number_quotient = {64'h5555_5555_5555_5555, 64'h0, 64'h1};
      push_product(active_select);
      fill_random(110);

      // each phase writes a divisor select; odd phases stop in mid-number so the
      // carry meets the next divisor
      for (int phase = 0; phase < 9; phase++) begin
         wait_idle();
         write_select(phase < 8 ? phase_select[phase] : SEL_WIDTH'($urandom_range(0, 3)));
         push_extremes();
         fill_random(100);
         if (phase % 2 == 1)
            push_word(random_limb(), 1'b0);
      end

      wait_idle();
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // hard stop, far beyond the slowest correct run
   initial begin
      #10_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
